>>> rtl/core/oteng_pkg.sv
// ----------------------------------------------------------------------------
// oteng_pkg
// Shared types and codes of the order trigger engine.
// ----------------------------------------------------------------------------
package oteng_pkg;

	localparam int ORDER_SLOTS_DEF = 64;
	localparam int PRICE_BITS_DEF  = 32;

	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] KIND_BUY_LIMIT  = 2'd2;
	localparam logic [1:0] KIND_SELL_LIMIT = 2'd3;

	localparam logic [1:0] OUT_EXPIRED = 2'd0;
	localparam logic [1:0] OUT_STOP    = 2'd1;
	localparam logic [1:0] OUT_TAKE    = 2'd2;
	localparam logic [1:0] OUT_REJECT  = 2'd3;

	// trigger classes in the order a tick walks them
	localparam logic [2:0] CLS_BUY_LIM  = 3'd0;
	localparam logic [2:0] CLS_SELL_LIM = 3'd1;
	localparam logic [2:0] CLS_BUY_SL   = 3'd2;
	localparam logic [2:0] CLS_BUY_TP   = 3'd3;
	localparam logic [2:0] CLS_SELL_SL  = 3'd4;
	localparam logic [2:0] CLS_SELL_TP  = 3'd5;

	typedef struct packed {
		logic        is_tick;
		logic        opens;
		logic [31:0] ident;
		logic [1:0]  kind;
		logic [31:0] entry;
		logic [31:0] tp;
		logic [31:0] sl;
		logic [23:0] vol;
		logic [47:0] expiry;
		logic [47:0] evt_time;
		logic [31:0] price;
	} req_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [1:0]  outcome;
		logic [1:0]  kind;
		logic [47:0] mtime;
		logic [63:0] profit;
		logic        last;
	} res_t;

	typedef struct packed {
		logic pop;
		logic hold_v;
	} back_stat_t;

endpackage

>>> rtl/core/oteng_front.sv
// ----------------------------------------------------------------------------
// oteng_front
// Accepts requests, decodes them and queues them for the execution side.
// ----------------------------------------------------------------------------
module oteng_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               opcode,
	input  logic [31:0]        order_ident,
	input  logic [1:0]         order_kind,
	input  logic [31:0]        entry_price,
	input  logic [31:0]        take_profit_price,
	input  logic [31:0]        stop_loss_price,
	input  logic [23:0]        lot_volume,
	input  logic [47:0]        expiry_time,
	input  logic [47:0]        event_time,
	input  logic [31:0]        tick_price,
	output logic               q_valid,
	output oteng_pkg::req_t    q_req,
	input  logic               q_pop
);

	oteng_pkg::req_t ent_q [2];
	oteng_pkg::req_t dec;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	always_comb begin
		dec.is_tick  = (opcode == oteng_pkg::OP_TICK);
		dec.opens    = (order_kind != oteng_pkg::KIND_BUY_LIMIT) &&
			(order_kind != oteng_pkg::KIND_SELL_LIMIT);
		dec.ident    = order_ident;
		dec.kind     = order_kind;
		dec.entry    = entry_price;
		dec.tp       = take_profit_price;
		dec.sl       = stop_loss_price;
		dec.vol      = lot_volume;
		dec.expiry   = expiry_time;
		dec.evt_time = event_time;
		dec.price    = tick_price;
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_req     = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= dec;
	end

endmodule

>>> rtl/core/oteng_profit.sv
// ----------------------------------------------------------------------------
// oteng_profit
// Three-stage saturating (a - b) * volume unit.
// ----------------------------------------------------------------------------
module oteng_profit #(
	parameter int PRICE_BITS = oteng_pkg::PRICE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [PRICE_BITS-1:0] a,
	input  logic [PRICE_BITS-1:0] b,
	input  logic [23:0]           vol,
	output logic                  done,
	output logic [63:0]           value
);

	localparam int PW = PRICE_BITS + 24;
	localparam int EW = (PW > 65) ? PW : 65;
	localparam logic [EW-1:0] HALF = EW'(1) << 63;

	logic                  v_s1, v_s2, v_s3;
	logic                  neg_s1, neg_s2;
	logic [PRICE_BITS-1:0] mag_s1;
	logic [23:0]           vol_s1;
	logic [PW-1:0]         prod_s2;
	logic [EW-1:0]         prod_x;
	logic [63:0]           value_s3;

	assign prod_x = EW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1   <= a < b;
		mag_s1   <= (a < b) ? (b - a) : (a - b);
		vol_s1   <= vol;
		neg_s2   <= neg_s1;
		prod_s2  <= PW'(mag_s1) * PW'(vol_s1);
		// clamp to the 64-bit range, negative side reaches one step further
		if (neg_s2) begin
			value_s3 <= (prod_x > HALF) ? 64'h8000_0000_0000_0000 : (64'd0 - prod_x[63:0]);
		end else begin
			value_s3 <= (prod_x >= HALF) ? 64'h7FFF_FFFF_FFFF_FFFF : prod_x[63:0];
		end
	end

	assign done  = v_s3;
	assign value = value_s3;

endmodule

>>> rtl/core/oteng_back.sv
// ----------------------------------------------------------------------------
// oteng_back
// Order table and the sequencer that executes adds and price ticks.
// ----------------------------------------------------------------------------
module oteng_back #(
	parameter int ORDER_SLOTS = oteng_pkg::ORDER_SLOTS_DEF,
	parameter int PRICE_BITS  = oteng_pkg::PRICE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  oteng_pkg::req_t        q_req,
	output logic                   q_pop,
	output oteng_pkg::res_t        rsp,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output oteng_pkg::back_stat_t  stat
);

	localparam int IW = $clog2(ORDER_SLOTS);
	localparam int CW = $clog2(ORDER_SLOTS + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(ORDER_SLOTS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FREE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_ARD   = 3'd3;
	localparam logic [2:0] ST_AEX   = 3'd4;
	localparam logic [2:0] ST_PWAIT = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	// order table
	logic [31:0]           mem_ident [ORDER_SLOTS];
	logic [1:0]            mem_kind  [ORDER_SLOTS];
	logic                  mem_open  [ORDER_SLOTS];
	logic [PRICE_BITS-1:0] mem_entry [ORDER_SLOTS];
	logic [PRICE_BITS-1:0] mem_tp    [ORDER_SLOTS];
	logic [PRICE_BITS-1:0] mem_sl    [ORDER_SLOTS];
	logic [23:0]           mem_vol   [ORDER_SLOTS];
	logic [47:0]           mem_exp   [ORDER_SLOTS];

	logic [31:0]           rd_ident_q;
	logic [1:0]            rd_kind_q;
	logic                  rd_open_q;
	logic [PRICE_BITS-1:0] rd_entry_q, rd_tp_q, rd_sl_q;
	logic [23:0]           rd_vol_q;
	logic [47:0]           rd_exp_q;

	logic [ORDER_SLOTS-1:0] valid_q;
	logic [2:0]             state_q;
	logic [CW-1:0]          cnt_q;
	logic [2:0]             cls_q;
	logic                   found_q;
	logic                   eval_v_s1;
	logic [IW-1:0]          idx_s1;
	logic [IW-1:0]          best_idx_q;
	logic [PRICE_BITS-1:0]  best_key_q;
	logic                   emit_fin_q;
	logic                   hold_v_q;
	logic                   out_v_q;
	oteng_pkg::res_t        new_q, hold_q, out_q;
	oteng_pkg::res_t        fin_res;

	logic [IW-1:0]          cnt_idx, rd_addr;
	logic                   cnt_end, issue, scan_done, wr_add, wr_open;
	logic                   out_free, emit_go, fin_go, expired, limit_cls;
	logic [PRICE_BITS-1:0]  price_m, key, pa, pb;
	logic                   qual, want_high, better, take;
	logic                   p_start, p_done;
	logic [63:0]            p_value;

	assign cnt_idx   = cnt_q[IW-1:0];
	assign cnt_end   = (cnt_q == LAST_CNT);
	assign issue     = (state_q == ST_SCAN) && !cnt_end;
	assign scan_done = (state_q == ST_SCAN) && cnt_end && !eval_v_s1;
	assign rd_addr   = (state_q == ST_ARD) ? best_idx_q : cnt_idx;
	assign wr_add    = (state_q == ST_FREE) && !cnt_end && !valid_q[cnt_idx];
	assign price_m   = PRICE_BITS'(q_req.price);
	assign limit_cls = (cls_q == oteng_pkg::CLS_BUY_LIM) || (cls_q == oteng_pkg::CLS_SELL_LIM);
	assign expired   = (rd_exp_q != 48'd0) && (rd_exp_q <= q_req.evt_time);
	assign wr_open   = (state_q == ST_AEX) && limit_cls && !expired;
	assign p_start   = (state_q == ST_AEX) && !limit_cls;
	assign out_free  = !out_v_q || !rsp_stall;
	assign emit_go   = (state_q == ST_EMIT) && (!hold_v_q || out_free);
	assign fin_go    = (state_q == ST_FIN) && (!hold_v_q || out_free);
	assign q_pop     = fin_go || wr_add;

	// qualification of the slot whose data just came out of the table
	always_comb begin
		key       = rd_entry_q;
		qual      = 1'b0;
		want_high = 1'b0;
		pa        = rd_sl_q;
		pb        = rd_entry_q;
		unique case (cls_q)
			oteng_pkg::CLS_BUY_LIM: begin
				want_high = 1'b1;
				qual = !rd_open_q && (rd_kind_q == oteng_pkg::KIND_BUY_LIMIT) && (key >= price_m);
			end
			oteng_pkg::CLS_SELL_LIM: begin
				qual = !rd_open_q && (rd_kind_q == oteng_pkg::KIND_SELL_LIMIT) && (key <= price_m);
			end
			oteng_pkg::CLS_BUY_SL: begin
				want_high = 1'b1;
				key  = rd_sl_q;
				qual = rd_open_q && !rd_kind_q[0] && (key >= price_m);
			end
			oteng_pkg::CLS_BUY_TP: begin
				key  = rd_tp_q;
				qual = rd_open_q && !rd_kind_q[0] && (key <= price_m);
				pa   = rd_tp_q;
			end
			oteng_pkg::CLS_SELL_SL: begin
				key  = rd_sl_q;
				qual = rd_open_q && rd_kind_q[0] && (key <= price_m);
				pa   = rd_entry_q;
				pb   = rd_sl_q;
			end
			default: begin
				want_high = 1'b1;
				key  = rd_tp_q;
				qual = rd_open_q && rd_kind_q[0] && (key >= price_m);
				pa   = rd_entry_q;
				pb   = rd_tp_q;
			end
		endcase
		better = want_high ? (key > best_key_q) : (key < best_key_q);
		take   = eval_v_s1 && valid_q[idx_s1] && qual && (!found_q || better);
	end

	// final response of a request carries the last flag
	always_comb begin
		fin_res      = hold_q;
		fin_res.last = 1'b1;
	end

	oteng_profit #(.PRICE_BITS(PRICE_BITS)) u_profit (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (p_start),
		.a      (pa),
		.b      (pb),
		.vol    (rd_vol_q),
		.done   (p_done),
		.value  (p_value)
	);

	always_ff @(posedge clk) begin
		if (wr_add) begin
			mem_ident[cnt_idx] <= q_req.ident;
			mem_kind[cnt_idx]  <= q_req.kind;
			mem_entry[cnt_idx] <= PRICE_BITS'(q_req.entry);
			mem_tp[cnt_idx]    <= PRICE_BITS'(q_req.tp);
			mem_sl[cnt_idx]    <= PRICE_BITS'(q_req.sl);
			mem_vol[cnt_idx]   <= q_req.vol;
			mem_exp[cnt_idx]   <= q_req.expiry;
		end
		if (wr_add) begin
			mem_open[cnt_idx] <= q_req.opens;
		end else if (wr_open) begin
			mem_open[best_idx_q] <= 1'b1;
		end
		rd_ident_q <= mem_ident[rd_addr];
		rd_kind_q  <= mem_kind[rd_addr];
		rd_open_q  <= mem_open[rd_addr];
		rd_entry_q <= mem_entry[rd_addr];
		rd_tp_q    <= mem_tp[rd_addr];
		rd_sl_q    <= mem_sl[rd_addr];
		rd_vol_q   <= mem_vol[rd_addr];
		rd_exp_q   <= mem_exp[rd_addr];
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cls_q      <= oteng_pkg::CLS_BUY_LIM;
			found_q    <= 1'b0;
			eval_v_s1  <= 1'b0;
			emit_fin_q <= 1'b0;
			hold_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
			valid_q    <= '0;
		end else begin
			eval_v_s1 <= issue;
			out_v_q   <= (out_v_q && rsp_stall) || ((emit_go || fin_go) && hold_v_q);
			unique case (state_q)
				ST_IDLE: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					cls_q   <= oteng_pkg::CLS_BUY_LIM;
					if (q_valid) state_q <= q_req.is_tick ? ST_SCAN : ST_FREE;
				end
				ST_FREE: begin
					if (cnt_end) begin
						emit_fin_q <= 1'b1;
						state_q    <= ST_EMIT;
					end else if (wr_add) begin
						valid_q[cnt_idx] <= 1'b1;
						state_q          <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				ST_SCAN: begin
					if (issue) cnt_q <= cnt_q + CW'(1);
					if (take) found_q <= 1'b1;
					if (scan_done) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						if (found_q) begin
							state_q <= ST_ARD;
						end else if (cls_q == oteng_pkg::CLS_SELL_TP) begin
							state_q <= ST_FIN;
						end else begin
							cls_q <= cls_q + 3'd1;
						end
					end
				end
				ST_ARD: state_q <= ST_AEX;
				ST_AEX: begin
					emit_fin_q <= 1'b0;
					if (!limit_cls) begin
						state_q <= ST_PWAIT;
					end else if (expired) begin
						valid_q[best_idx_q] <= 1'b0;
						state_q             <= ST_EMIT;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_PWAIT: begin
					if (p_done) begin
						valid_q[best_idx_q] <= 1'b0;
						state_q             <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						hold_v_q <= 1'b1;
						state_q  <= emit_fin_q ? ST_FIN : ST_SCAN;
					end
				end
				default: begin
					if (fin_go) begin
						hold_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		idx_s1 <= cnt_idx;
		if (take) begin
			best_idx_q <= idx_s1;
			best_key_q <= key;
		end
		if ((state_q == ST_FREE) && cnt_end) begin
			new_q.ident   <= q_req.ident;
			new_q.outcome <= oteng_pkg::OUT_REJECT;
			new_q.kind    <= q_req.kind;
			new_q.mtime   <= 48'd0;
			new_q.profit  <= 64'd0;
			new_q.last    <= 1'b0;
		end
		if (state_q == ST_AEX) begin
			new_q.ident  <= rd_ident_q;
			new_q.kind   <= rd_kind_q;
			new_q.mtime  <= q_req.evt_time;
			new_q.profit <= 64'd0;
			new_q.last   <= 1'b0;
			if (limit_cls) begin
				new_q.outcome <= oteng_pkg::OUT_EXPIRED;
			end else if ((cls_q == oteng_pkg::CLS_BUY_SL) || (cls_q == oteng_pkg::CLS_SELL_SL)) begin
				new_q.outcome <= oteng_pkg::OUT_STOP;
			end else begin
				new_q.outcome <= oteng_pkg::OUT_TAKE;
			end
		end
		if ((state_q == ST_PWAIT) && p_done) new_q.profit <= p_value;
		if (emit_go) begin
			hold_q <= new_q;
			if (hold_v_q) out_q <= hold_q;
		end
		if (fin_go && hold_v_q) begin
			out_q <= fin_res;
		end
	end

	assign rsp         = out_q;
	assign rsp_valid   = out_v_q;
	assign stat.pop    = q_pop;
	assign stat.hold_v = hold_v_q;

endmodule

>>> rtl/core/order_trigger_engine_top.sv
// ----------------------------------------------------------------------------
// order_trigger_engine_top
// Order table with limit entry, stop loss and take profit triggering.
// ----------------------------------------------------------------------------
// A request either adds an order or delivers a price tick. Adds take the
// lowest free slot; a full table answers with one "rejected full" response.
// A tick walks six trigger classes (buy limits, sell limits, buy stop loss,
// buy take profit, sell stop loss, sell take profit), and within a class it
// reports orders best price first, lower slot first on ties. The last
// response of a request carries last_of_run. Requests queue two deep in
// front of the executor, and one finished response waits in an output
// register, so requests that produce no response keep flowing while
// responses stall. An add scans the slots upward from the lowest index
// until it finds a free one. Each trigger decision of a tick is one full
// pass over the table through its single read port, one slot per cycle,
// and each closing order also runs through the three-stage profit
// multiplier.
// ----------------------------------------------------------------------------
module order_trigger_engine_top #(
	parameter int ORDER_SLOTS = oteng_pkg::ORDER_SLOTS_DEF,
	parameter int PRICE_BITS  = oteng_pkg::PRICE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic               opcode,
	input  logic [31:0]        order_ident,
	input  logic [1:0]         order_kind,
	input  logic [31:0]        entry_price,
	input  logic [31:0]        take_profit_price,
	input  logic [31:0]        stop_loss_price,
	input  logic [23:0]        lot_volume,
	input  logic [47:0]        expiry_time,
	input  logic [47:0]        event_time,
	input  logic [31:0]        tick_price,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [31:0]        closed_ident,
	output logic [1:0]         outcome,
	output logic [1:0]         closed_kind,
	output logic [47:0]        match_time,
	output logic signed [63:0] profit,
	output logic               last_of_run
);

	logic                  q_valid;
	logic                  q_pop;
	oteng_pkg::req_t       q_req;
	oteng_pkg::res_t       rsp;
	oteng_pkg::back_stat_t stat;

	// decode and queue requests
	oteng_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_valid         (req_valid),
		.req_stall         (req_stall),
		.opcode            (opcode),
		.order_ident       (order_ident),
		.order_kind        (order_kind),
		.entry_price       (entry_price),
		.take_profit_price (take_profit_price),
		.stop_loss_price   (stop_loss_price),
		.lot_volume        (lot_volume),
		.expiry_time       (expiry_time),
		.event_time        (event_time),
		.tick_price        (tick_price),
		.q_valid           (q_valid),
		.q_req             (q_req),
		.q_pop             (q_pop)
	);

	// execute adds and ticks against the order table
	oteng_back #(
		.ORDER_SLOTS (ORDER_SLOTS),
		.PRICE_BITS  (PRICE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat)
	);

	assign closed_ident = rsp.ident;
	assign outcome      = rsp.outcome;
	assign closed_kind  = rsp.kind;
	assign match_time   = rsp.mtime;
	assign profit       = signed'(rsp.profit);
	assign last_of_run  = rsp.last;

`ifndef SYNTHESIS
	// drop a request from the queue only when one is there
	a_pop_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |-> q_valid)
		else $error("queue popped while empty");

	// the held response is flushed before the request retires
	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		stat.pop |=> !stat.hold_v)
		else $error("response still held after request retired");
`endif

endmodule

>>> bench/order_trigger_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_trigger_engine_top_tb
// Self-checking bench: directed and random add/tick requests against a
// behavioral order table, responses compared field by field in order.
// ----------------------------------------------------------------------------
module order_trigger_engine_top_tb;

	localparam int SLOTS    = oteng_pkg::ORDER_SLOTS_DEF;
	localparam int IDLE_MAX = 20000;
	localparam int LONG_HOLD = 3000;
	localparam logic OP_ADD = 1'b0;
	localparam logic [1:0] KIND_BUY_MKT  = 2'd0;
	localparam logic [1:0] KIND_SELL_MKT = 2'd1;

	typedef struct {
		logic        op;
		logic [31:0] ident;
		logic [1:0]  kind;
		logic [31:0] entry;
		logic [31:0] tp;
		logic [31:0] sl;
		logic [23:0] vol;
		logic [47:0] expiry;
		logic [47:0] etime;
		logic [31:0] price;
	} request_t;

	typedef struct {
		logic [31:0]        ident;
		logic [1:0]         outcome;
		logic [1:0]         kind;
		logic [47:0]        mtime;
		logic signed [63:0] profit;
		logic               last;
	} report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic opcode = 1'b0;
	logic [31:0] order_ident = '0;
	logic [1:0] order_kind = '0;
	logic [31:0] entry_price = '0;
	logic [31:0] take_profit_price = '0;
	logic [31:0] stop_loss_price = '0;
	logic [23:0] lot_volume = '0;
	logic [47:0] expiry_time = '0;
	logic [47:0] event_time = '0;
	logic [31:0] tick_price = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b1;
	logic [31:0] closed_ident;
	logic [1:0] outcome;
	logic [1:0] closed_kind;
	logic [47:0] match_time;
	logic signed [63:0] profit;
	logic last_of_run;

	order_trigger_engine_top dut (.*);

	// behavioral copy of the order table
	logic        tbl_valid [SLOTS];
	logic        tbl_open  [SLOTS];
	logic [1:0]  tbl_kind  [SLOTS];
	logic [31:0] tbl_ident [SLOTS];
	logic [31:0] tbl_entry [SLOTS];
	logic [31:0] tbl_tp    [SLOTS];
	logic [31:0] tbl_sl    [SLOTS];
	logic [23:0] tbl_vol   [SLOTS];
	logic [47:0] tbl_exp   [SLOTS];

	request_t pending_reqs[$];
	report_t  expected_reports[$];
	int       mismatches = 0;
	int       idle_cycles = 0;
	bit       stim_done = 0;
	logic     req_taken = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	// append a request to the stimulus queue
	task automatic queue_req(request_t r);
		pending_reqs = {pending_reqs, r};
	endtask

	// append an expected response
	task automatic queue_report(report_t rep);
		expected_reports = {expected_reports, rep};
	endtask

	// (a - b) * vol as a signed 64-bit value (the product never needs saturation)
	function automatic logic signed [63:0] sat_gain(logic [31:0] a, logic [31:0] b,
			logic [23:0] vol);
		logic [32:0] mag;
		logic [56:0] prod;
		mag  = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
		prod = mag * vol;
		return (a >= b) ? $signed({7'b0, prod}) : -$signed({7'b0, prod});
	endfunction

	function automatic bit qualifies(int s, int cls, logic [31:0] px, output logic [31:0] key);
		logic buy;
		buy = ~tbl_kind[s][0];
		key = '0;
		if (!tbl_valid[s])
			return 0;
		case (cls)
			oteng_pkg::CLS_BUY_LIM: begin key = tbl_entry[s];
				return !tbl_open[s] && tbl_kind[s] == oteng_pkg::KIND_BUY_LIMIT && key >= px; end
			oteng_pkg::CLS_SELL_LIM: begin key = tbl_entry[s];
				return !tbl_open[s] && tbl_kind[s] == oteng_pkg::KIND_SELL_LIMIT && key <= px; end
			oteng_pkg::CLS_BUY_SL: begin key = tbl_sl[s];
				return tbl_open[s] && buy && key >= px; end
			oteng_pkg::CLS_BUY_TP: begin key = tbl_tp[s];
				return tbl_open[s] && buy && key <= px; end
			oteng_pkg::CLS_SELL_SL: begin key = tbl_sl[s];
				return tbl_open[s] && !buy && key <= px; end
			default: begin key = tbl_tp[s]; return tbl_open[s] && !buy && key >= px; end
		endcase
	endfunction

	function automatic int pick_next(int cls, logic [31:0] px);
		int best;
		logic [31:0] bkey, key;
		bit hi;
		best = -1;
		bkey = '0;
		hi = (cls == oteng_pkg::CLS_BUY_LIM || cls == oteng_pkg::CLS_BUY_SL ||
			cls == oteng_pkg::CLS_SELL_TP);
		for (int s = 0; s < SLOTS; s++)
			if (qualifies(s, cls, px, key))
				if (best < 0 || (hi ? key > bkey : key < bkey)) begin
					best = s;
					bkey = key;
				end
		return best;
	endfunction

	// apply one accepted request to the table and queue its reports
	task automatic predict_request(request_t r);
		int s, n;
		report_t rep;
		n = 0;
		if (r.op == OP_ADD) begin
			for (s = 0; s < SLOTS; s++)
				if (!tbl_valid[s])
					break;
			if (s >= SLOTS) begin
				rep = '{r.ident, oteng_pkg::OUT_REJECT, r.kind, 48'd0, 64'sd0, 1'b1};
				queue_report(rep);
				return;
			end
			tbl_valid[s] = 1;
			tbl_kind[s]  = r.kind;
			tbl_open[s]  = (r.kind == KIND_BUY_MKT || r.kind == KIND_SELL_MKT);
			tbl_ident[s] = r.ident;
			tbl_entry[s] = r.entry;
			tbl_tp[s]    = r.tp;
			tbl_sl[s]    = r.sl;
			tbl_vol[s]   = r.vol;
			tbl_exp[s]   = r.expiry;
			return;
		end
		for (int cls = 0; cls < 6; cls++) begin
			forever begin
				s = pick_next(cls, r.price);
				if (s < 0)
					break;
				rep.ident = tbl_ident[s];
				rep.kind  = tbl_kind[s];
				rep.mtime = r.etime;
				rep.last  = 0;
				if (cls < 2) begin
					if (tbl_exp[s] != 0 && tbl_exp[s] <= r.etime) begin
						rep.outcome = oteng_pkg::OUT_EXPIRED;
						rep.profit = 0;
						queue_report(rep);
						n++;
						tbl_valid[s] = 0;
					end else
						tbl_open[s] = 1;
				end else begin
					case (cls)
						oteng_pkg::CLS_BUY_SL: begin rep.outcome = oteng_pkg::OUT_STOP;
							rep.profit = sat_gain(tbl_sl[s], tbl_entry[s], tbl_vol[s]); end
						oteng_pkg::CLS_BUY_TP: begin rep.outcome = oteng_pkg::OUT_TAKE;
							rep.profit = sat_gain(tbl_tp[s], tbl_entry[s], tbl_vol[s]); end
						oteng_pkg::CLS_SELL_SL: begin rep.outcome = oteng_pkg::OUT_STOP;
							rep.profit = sat_gain(tbl_entry[s], tbl_sl[s], tbl_vol[s]); end
						default: begin rep.outcome = oteng_pkg::OUT_TAKE;
							rep.profit = sat_gain(tbl_entry[s], tbl_tp[s], tbl_vol[s]); end
					endcase
					queue_report(rep);
					n++;
					tbl_valid[s] = 0;
				end
			end
		end
		if (n > 0)
			expected_reports[$].last = 1;
	endtask

	function automatic request_t make_add(logic [1:0] kind, logic [31:0] entry,
			logic [31:0] tp, logic [31:0] sl, logic [23:0] vol, logic [47:0] expiry);
		request_t r;
		r = '{OP_ADD, $urandom, kind, entry, tp, sl, vol, expiry, 48'({$urandom, $urandom}),
			$urandom};
		return r;
	endfunction

	function automatic request_t make_tick(logic [31:0] px, logic [47:0] t);
		request_t r;
		r = '{oteng_pkg::OP_TICK, $urandom, 2'($urandom), $urandom, $urandom, $urandom,
			24'($urandom), 48'({$urandom, $urandom}), t, px};
		return r;
	endfunction

	// a bracketed order around a center price: buys stop below, take above
	function automatic request_t bracket(logic [31:0] center, logic [47:0] expiry);
		logic [1:0] k;
		logic [31:0] e, d1, d2;
		k  = 2'($urandom);
		d1 = $urandom_range(1, 500);
		d2 = $urandom_range(1, 500);
		e  = center + $urandom_range(0, 400) - 200;
		if (k[0] == 0)
			return make_add(k, e, e + d1, e - d2, 24'($urandom_range(0, 1000)), expiry);
		return make_add(k, e, e - d1, e + d2, 24'($urandom_range(0, 1000)), expiry);
	endfunction

	// fill the request queue: directed corners first, then random rounds
	initial begin
		logic [31:0] center;
		logic [47:0] now;
		for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 0;
		// large profits both ways, zero volume, all-ones fields
		queue_req(make_add(KIND_BUY_MKT, 32'd0, 32'hFFFF_FFFF, 32'd0,
			24'hFF_FFFF, 48'd0));
		queue_req(make_add(KIND_SELL_MKT, 32'd0, 32'd0, 32'hFFFF_FFFF,
			24'hFF_FFFF, 48'hFFFF_FFFF_FFFF));
		queue_req(make_add(KIND_BUY_MKT, 32'd5, 32'd9, 32'd1, 24'd0, 48'd0));
		queue_req(make_tick(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		queue_req(make_tick(32'd0, 48'd1));
		// limits: one expires, one opens and closes in the same tick, equal keys
		queue_req(make_add(oteng_pkg::KIND_BUY_LIMIT, 32'd100, 32'd200, 32'd50, 24'd3, 48'd10));
		queue_req(make_add(oteng_pkg::KIND_BUY_LIMIT, 32'd100, 32'd200, 32'd99, 24'd2, 48'd0));
		queue_req(make_add(oteng_pkg::KIND_SELL_LIMIT, 32'd100, 32'd50, 32'd150, 24'd4, 48'd11));
		queue_req(make_add(oteng_pkg::KIND_SELL_LIMIT, 32'd90, 32'd95, 32'd300, 24'd4, 48'd0));
		queue_req(make_tick(32'd98, 48'd10));
		queue_req(make_tick(32'd100, 48'd20));
		queue_req(make_tick(32'd200, 48'd30));
		queue_req(make_tick(32'd0, 48'd40));
		queue_req(make_tick(32'hFFFF_FFFF, 48'd41));
		// overfill the table to hit rejects, then clear it
		for (int i = 0; i < SLOTS + 2; i++)
			queue_req(make_add(KIND_BUY_MKT, 32'd1000, 32'd2000, 32'd10,
				24'($urandom), 48'd0));
		queue_req(make_tick(32'd5, 48'd50));
		// random rounds: a few brackets around a price, then ticks wandering nearby
		now = 48'd100;
		for (int round = 0; round < 20; round++) begin
			center = $urandom_range(1000, 32'hFFF0_0000);
			repeat ($urandom_range(2, 6)) begin
				if ($urandom_range(0, 9) == 0)
					queue_req(make_add(2'($urandom), $urandom, $urandom, $urandom,
						24'($urandom), 48'({$urandom, $urandom})));
				else
					queue_req(bracket(center,
						$urandom_range(0, 1) ? 48'd0 : now + 48'($urandom_range(0, 40))));
			end
			repeat ($urandom_range(1, 3)) begin
				now += 48'($urandom_range(0, 30));
				queue_req(make_tick(center + $urandom_range(0, 1200) - 600, now));
			end
		end
		queue_req(make_tick(32'd0, now + 48'd1));
		queue_req(make_tick(32'hFFFF_FFFF, now + 48'd2));
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// driver: bursts and gaps, payload held while stalled
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		request_t r;
		if (arst_n && (!req_valid || req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				req_valid <= 1'b1;
				opcode <= r.op;
				order_ident <= r.ident;
				order_kind <= r.kind;
				entry_price <= r.entry;
				take_profit_price <= r.tp;
				stop_loss_price <= r.sl;
				lot_volume <= r.vol;
				expiry_time <= r.expiry;
				event_time <= r.etime;
				tick_price <= r.price;
				if (burst_left > 0)
					burst_left--;
				else begin
					burst_left = $urandom_range(0, 12);
					gap_left = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
				end
			end else
				req_valid <= 1'b0;
		end
	end

	// request acceptance: predict and tell the driver to advance
	always @(posedge clk) begin
		request_t r;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			r = '{opcode, order_ident, order_kind, entry_price, take_profit_price,
				stop_loss_price, lot_volume, expiry_time, event_time, tick_price};
			predict_request(r);
		end
		if (arst_n && pending_reqs.size() == 0 && !req_valid)
			stim_done <= 1'b1;
	end

	// receiver stall pattern, with one long hold-off while requests remain
	int rsp_cycle = 0;
	int long_left = 0;
	bit long_done = 0;
	always @(negedge clk) begin
		rsp_cycle++;
		if (long_left > 0) begin
			long_left--;
			rsp_stall <= 1'b1;
		end else if (!long_done && arst_n && rsp_valid && pending_reqs.size() > 20) begin
			long_done = 1;
			long_left = LONG_HOLD;
			rsp_stall <= 1'b1;
		end else if (rsp_cycle[9])
			rsp_stall <= 1'b0;
		else
			rsp_stall <= ($urandom_range(0, 3) == 0);
	end

	// monitor: compare each response with the oldest expectation
	always @(posedge clk) begin
		report_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response ident %h outcome %0d", closed_ident, outcome);
			end else begin
				e = expected_reports.pop_front();
				if (closed_ident !== e.ident || outcome !== e.outcome || closed_kind !== e.kind
						|| match_time !== e.mtime || profit !== e.profit
						|| last_of_run !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0d/%0d/%0d/%b got %h/%0d/%0d/%0d/%0d/%b",
							e.ident, e.outcome, e.kind, e.mtime, e.profit, e.last,
							closed_ident, outcome, closed_kind, match_time, profit,
							last_of_run);
				end
			end
		end
	end

	// watchdog: count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		do
			@(posedge clk);
		while (!((stim_done && expected_reports.size() == 0) || idle_cycles >= IDLE_MAX));
		if (idle_cycles >= IDLE_MAX) begin
			$display("tb: failure");
		end else begin
			repeat (500) @(posedge clk);
			if (mismatches == 0 && expected_reports.size() == 0)
				$display("tb: success");
			else
				$display("tb: failure");
		end
		$finish;
	end

endmodule
